FILE: rtl/mssis_pkg.sv
// ----------------------------------------------------------------------------
// Subset-sum image size package
// Shared widths, constants and helper functions.
// ----------------------------------------------------------------------------
package mssis_pkg;

  localparam int unsigned FieldW   = 16;
  localparam int unsigned WordBits = 64;
  localparam int unsigned LogW     = 6;
  localparam int unsigned NBitsW   = LogW + 1;

  typedef logic [FieldW-1:0]   field_t;
  typedef logic [WordBits-1:0] word_t;
  typedef logic [NBitsW-1:0]   nbits_t;

  function automatic word_t low_mask(nbits_t n);
    word_t m;
    if (n >= nbits_t'(WordBits)) begin
      m = '1;
    end else begin
      m = ~({WordBits{1'b1}} << n);
    end
    return m;
  endfunction

  function automatic nbits_t min_bits(field_t a, nbits_t b);
    nbits_t r;
    if (a > field_t'(b)) begin
      r = b;
    end else begin
      r = nbits_t'(a);
    end
    return r;
  endfunction

endpackage

FILE: rtl/mssis_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the limit and the modulus of one request.
// ----------------------------------------------------------------------------
interface mssis_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] subset_limit;
  logic [15:0] prime_modulus;

  modport source (output valid, output subset_limit, output prime_modulus, input ready);
  modport sink (input valid, input subset_limit, input prime_modulus, output ready);
endinterface

FILE: rtl/mssis_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the image size and the bad-request flag.
// ----------------------------------------------------------------------------
interface mssis_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] image_count;
  logic        bad_request;

  modport source (output valid, output image_count, output bad_request, input ready);
  modport sink (input valid, input image_count, input bad_request, output ready);
endinterface

FILE: rtl/mssis_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider, one quotient bit a cycle, 32-bit dividend, 16-bit divisor.
// ----------------------------------------------------------------------------
module mssis_div
  import mssis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  field_t      divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output field_t      rem_o
);

  logic [31:0] dvd_q;
  logic [16:0] rem_q;
  field_t      dsr_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_q[15:0], dvd_q[31]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q <= dividend_i;
        rem_q <= '0;
        dsr_q <= divisor_i;
        cnt_q <= 6'd32;
      end else if (cnt_q != '0) begin
        rem_q  <= fits ? (trial - {1'b0, dsr_q}) : trial;
        dvd_q  <= {dvd_q[30:0], fits};
        cnt_q  <= cnt_q - 6'd1;
        done_q <= (cnt_q == 6'd1);
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q[15:0];

endmodule

FILE: rtl/modular_subset_sum_image_size_unit.sv
// ----------------------------------------------------------------------------
// Modular subset-sum image size unit
// Counts the residues mod p reachable as sums of subsets of 1/1 .. 1/m.
// ----------------------------------------------------------------------------
// One request at a time; in_i.ready is high only while idle. A request runs
// m-1 inverse steps (a load state, a wait on the shared divider, a multiply
// state and a second wait on the divider), a clear sweep of the bitset words,
// m rotate passes over the two-bank bitset memory (a pass does no memory
// sweep where the inverse is zero), and a count sweep. A bad request raises
// its result in the cycle after it is accepted.
module modular_subset_sum_image_size_unit
  import mssis_pkg::*;
#(
  parameter int unsigned MAX_MODULUS = 65535
) (
  input  logic clk_i,
  input  logic rst_ni,
  mssis_in_if.sink    in_i,
  mssis_out_if.source out_o
);

  localparam int unsigned ModLim   = (MAX_MODULUS > 65535) ? 65535 : MAX_MODULUS;
  localparam int unsigned InvDepth = ModLim + 1;
  localparam int unsigned InvAw    = $clog2(InvDepth);
  localparam int unsigned NWords   = (ModLim + WordBits - 1) / WordBits;
  localparam int unsigned WIdx     = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int unsigned BitDepth = 2 ** (WIdx + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LD1, S_DIV1, S_MUL, S_DIV2, S_CLR, S_KRD, S_KSET,
    S_RD1, S_RD2, S_WR, S_CNT, S_CNT2, S_DONE
  } state_e;

  typedef logic [WIdx-1:0] widx_t;

  state_e      state_q;
  field_t      m_q, p_q, k_q, q16_q, pos_q;
  logic [16:0] y0_q;
  widx_t       w_q;
  logic        src_q, rzero_q;
  word_t       wa_q, wb_q;
  logic [16:0] cnt_q;
  logic        bad_q, ovalid_q;

  field_t      inv_mem [InvDepth];
  field_t      inv_rd_q;
  logic [InvAw-1:0] inv_raddr, inv_waddr;
  field_t      inv_wdata;
  logic        inv_we;

  word_t       bit_mem [BitDepth];
  word_t       rda_q, rdb_q;
  logic [WIdx:0] addr_a, addr_b, waddr;
  word_t       wdata;
  logic        bit_we;

  logic        div_start, div_done;
  logic [31:0] div_dvd, div_quot;
  field_t      div_dsr, div_rem;

  logic        accept, bad_in, last_w;
  widx_t       nw_m1, qidx;
  field_t      s_val, p_minus_s;
  logic [16:0] pos_next;
  nbits_t      n_bits, n1_bits;
  logic [2*WordBits-1:0] window;
  word_t       rot_word;

  assign accept = in_i.valid && in_i.ready;
  assign bad_in = (in_i.subset_limit == '0) || (in_i.subset_limit >= in_i.prime_modulus)
               || ({16'b0, in_i.prime_modulus} > 32'(MAX_MODULUS));
  assign nw_m1  = widx_t'((p_q - 16'd1) >> LogW);
  assign last_w = (w_q == nw_m1);
  assign qidx   = widx_t'(pos_q >> LogW);
  assign s_val  = inv_rd_q;
  assign p_minus_s = p_q - s_val;
  assign pos_next  = 17'(pos_q) + 17'(WordBits);

  assign n_bits  = min_bits(p_q - y0_q[15:0], nbits_t'(WordBits));
  assign n1_bits = min_bits(p_q - pos_q, n_bits);
  assign window  = {wb_q, wa_q} >> pos_q[LogW-1:0];
  assign rot_word = (window[WordBits-1:0] & low_mask(n1_bits))
                  | ((rdb_q & low_mask(n_bits - n1_bits)) << n1_bits);

  mssis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign div_start = (state_q == S_LD1) || (state_q == S_MUL);
  assign div_dvd   = (state_q == S_LD1) ? {16'b0, p_q}
                   : (32'(q16_q) * 32'(rzero_q ? 16'd0 : inv_rd_q));
  assign div_dsr   = (state_q == S_LD1) ? k_q : p_q;

  always_comb begin
    inv_we    = 1'b0;
    inv_waddr = k_q[InvAw-1:0];
    inv_wdata = (div_rem == '0) ? '0 : (p_q - div_rem);
    if (state_q == S_IDLE) begin
      inv_we    = accept && !bad_in;
      inv_waddr = InvAw'(1);
      inv_wdata = 16'd1;
    end else if (state_q == S_DIV2) begin
      inv_we = div_done;
    end
  end

  assign inv_raddr = (state_q == S_DIV1) ? div_rem[InvAw-1:0] : k_q[InvAw-1:0];

  always_ff @(posedge clk_i) begin
    if (inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
    inv_rd_q <= inv_mem[inv_raddr];
  end

  always_comb begin
    addr_a = {src_q, w_q};
    addr_b = {src_q, widx_t'(0)};
    if (state_q == S_RD1) begin
      addr_a = {src_q, qidx};
      addr_b = {src_q, qidx + widx_t'(1)};
    end
    bit_we = (state_q == S_CLR) || (state_q == S_WR);
    waddr  = (state_q == S_CLR) ? {src_q, w_q} : {~src_q, w_q};
    wdata  = (state_q == S_CLR) ? word_t'(w_q == '0) : (rda_q | rot_word);
  end

  always_ff @(posedge clk_i) begin
    if (bit_we) begin
      bit_mem[waddr] <= wdata;
    end
    rda_q <= bit_mem[addr_a];
    rdb_q <= bit_mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      bad_q    <= 1'b0;
      src_q    <= 1'b0;
      m_q      <= '0;
      p_q      <= '0;
      k_q      <= '0;
      q16_q    <= '0;
      pos_q    <= '0;
      y0_q     <= '0;
      w_q      <= '0;
      rzero_q  <= 1'b0;
      wa_q     <= '0;
      wb_q     <= '0;
      cnt_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            m_q <= in_i.subset_limit;
            p_q <= in_i.prime_modulus;
            k_q <= 16'd2;
            w_q <= '0;
            cnt_q <= '0;
            if (bad_in) begin
              bad_q    <= 1'b1;
              ovalid_q <= 1'b1;
              state_q  <= S_DONE;
            end else begin
              bad_q   <= 1'b0;
              state_q <= (in_i.subset_limit == 16'd1) ? S_CLR : S_LD1;
            end
          end
        end
        S_LD1: state_q <= S_DIV1;
        S_DIV1: begin
          if (div_done) begin
            q16_q   <= div_quot[15:0];
            rzero_q <= (div_rem == '0);
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_DIV2;
        S_DIV2: begin
          if (div_done) begin
            if (k_q == m_q) begin
              w_q     <= '0;
              state_q <= S_CLR;
            end else begin
              k_q     <= k_q + 16'd1;
              state_q <= S_LD1;
            end
          end
        end
        S_CLR: begin
          if (last_w) begin
            k_q     <= 16'd1;
            state_q <= S_KRD;
          end else begin
            w_q <= w_q + widx_t'(1);
          end
        end
        S_KRD: state_q <= S_KSET;
        S_KSET: begin
          w_q  <= '0;
          y0_q <= '0;
          pos_q <= p_minus_s;
          if (s_val != '0) begin
            state_q <= S_RD1;
          end else if (k_q == m_q) begin
            cnt_q   <= '0;
            state_q <= S_CNT;
          end else begin
            k_q     <= k_q + 16'd1;
            state_q <= S_KRD;
          end
        end
        S_RD1: state_q <= S_RD2;
        S_RD2: begin
          wa_q    <= rda_q;
          wb_q    <= rdb_q;
          state_q <= S_WR;
        end
        S_WR: begin
          if (last_w) begin
            src_q <= ~src_q;
            w_q   <= '0;
            if (k_q == m_q) begin
              cnt_q   <= '0;
              state_q <= S_CNT;
            end else begin
              k_q     <= k_q + 16'd1;
              state_q <= S_KRD;
            end
          end else begin
            w_q   <= w_q + widx_t'(1);
            y0_q  <= y0_q + 17'(WordBits);
            pos_q <= (pos_next >= 17'(p_q)) ? field_t'(pos_next - 17'(p_q))
                                           : pos_next[15:0];
            state_q <= S_RD1;
          end
        end
        S_CNT: state_q <= S_CNT2;
        S_CNT2: begin
          cnt_q <= cnt_q + 17'($countones(rda_q));
          if (last_w) begin
            ovalid_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            w_q     <= w_q + widx_t'(1);
            state_q <= S_CNT;
          end
        end
        S_DONE: begin
          if (out_o.ready) begin
            ovalid_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = ovalid_q;
  assign out_o.image_count = bad_q ? 16'd0 : cnt_q[15:0];
  assign out_o.bad_request = bad_q;

endmodule
